// File: design/lc3b_pkg.sv
// lc3b_pkg: shared types and constants for the LC-3b executor.
// No dependencies.
package lc3b_pkg;

  localparam int MEM_WORDS_DEF = 32768;

  localparam logic [3:0] OP_BR   = 4'h0;
  localparam logic [3:0] OP_ADD  = 4'h1;
  localparam logic [3:0] OP_LDB  = 4'h2;
  localparam logic [3:0] OP_STB  = 4'h3;
  localparam logic [3:0] OP_JSR  = 4'h4;
  localparam logic [3:0] OP_AND  = 4'h5;
  localparam logic [3:0] OP_LDW  = 4'h6;
  localparam logic [3:0] OP_STW  = 4'h7;
  localparam logic [3:0] OP_XOR  = 4'h9;
  localparam logic [3:0] OP_JMP  = 4'hC;
  localparam logic [3:0] OP_SHF  = 4'hD;
  localparam logic [3:0] OP_LEA  = 4'hE;
  localparam logic [3:0] OP_TRAP = 4'hF;

  localparam logic [1:0] SK_NONE = 2'd0;
  localparam logic [1:0] SK_BYTE = 2'd1;
  localparam logic [1:0] SK_WORD = 2'd2;

  localparam logic [2:0] CC_Z = 3'b010;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_EXEC, ST_MEM, ST_DONE
  } state_t;

  // memory address source selection
  typedef enum logic [1:0] {
    MA_CLEAR, MA_PC, MA_DATA, MA_LOAD
  } maddr_sel_t;

  typedef struct packed {
    logic       clear_step; // write zero at clear counter
    logic       clear_init;
    maddr_sel_t maddr_sel;
    logic       mem_rd;
    logic       inst_load;  // latch fetched word
    logic       exec;       // evaluate instruction, latch results
    logic       finish;     // commit results of the memory step (load data or store)
    logic       load_item;  // commit load item
    logic       halt_item;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic pc_zero;
    logic needs_mem;  // instruction reads or writes memory after exec
  } status_t;

endpackage

// File: design/lc3b_ctrl.sv
// lc3b_ctrl: sequencer for the LC-3b executor.
// Depends on lc3b_pkg.
module lc3b_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              func,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  lc3b_pkg::status_t sts,
  output lc3b_pkg::cmd_t    cmd
);
  import lc3b_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.clear_init = rst;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        cmd.maddr_sel  = MA_CLEAR;
        if (sts.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func) begin
            cmd.maddr_sel = MA_LOAD;
            cmd.load_item = 1'b1;
            state_next    = ST_DONE;
          end else if (sts.pc_zero) begin
            cmd.halt_item = 1'b1;
            state_next    = ST_DONE;
          end else begin
            cmd.maddr_sel = MA_PC;
            cmd.mem_rd    = 1'b1;
            state_next    = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        cmd.inst_load = 1'b1;
        state_next    = ST_EXEC;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        state_next = sts.needs_mem ? ST_MEM : ST_DONE;
      end
      ST_MEM: begin
        cmd.maddr_sel = MA_DATA;
        cmd.mem_rd    = 1'b1;
        cmd.finish    = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// File: design/lc3b_dp.sv
// lc3b_dp: register file, PC, codes, memory and execute logic.
// Depends on lc3b_pkg.
module lc3b_dp #(
  parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  lc3b_pkg::cmd_t    cmd,
  output lc3b_pkg::status_t sts,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_pc,
  input  logic [14:0]       load_addr,
  input  logic [15:0]       load_word,
  output logic [15:0]       next_pc,
  output logic              halted,
  output logic [2:0]        cond_flags,
  output logic              dest_written,
  output logic [2:0]        dest_index,
  output logic [15:0]       dest_value,
  output logic [1:0]        store_kind,
  output logic [15:0]       store_addr,
  output logic [15:0]       store_data
);
  import lc3b_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [15:0] mem [MEM_WORDS];
  logic [15:0] rf [8];
  logic [15:0] pc;
  logic [2:0]  cc;
  logic [15:0] inst;
  logic [15:0] mem_q;
  logic [AW:0] clr_cnt;

  // registered execute results
  logic [15:0] addr;     // data byte address
  logic        mem_kind; // 1 read for LDB/LDW/TRAP, 0 store
  logic [15:0] pc_ex;
  logic [15:0] v_ex;
  logic [2:0]  dr_ex;
  logic [1:0]  sk_ex;
  logic [15:0] sd_ex;

  // decode / execute
  logic [3:0]  op;
  logic [2:0]  dr, sr1;
  logic [15:0] a, b, sx5, sx6, sx9, sx11, pc2;
  logic [15:0] ex_addr, ex_pc, ex_v;
  logic        ex_wr, ex_setcc, ex_mem, ex_rd;
  logic [1:0]  ex_sk;
  logic [2:0]  ex_dr;

  // memory port
  logic [AW-1:0] maddr;
  logic          mwe;
  logic [15:0]   mwdata;

  always_comb begin
    maddr  = '0;
    mwe    = 1'b0;
    mwdata = load_word;
    case (cmd.maddr_sel)
      MA_CLEAR: begin
        maddr  = clr_cnt[AW-1:0];
        mwe    = cmd.clear_step;
        mwdata = '0;
      end
      MA_PC:   maddr = pc[AW:1];
      MA_DATA: begin
        maddr = addr[AW:1];
        mwe   = cmd.finish && !mem_kind;
        if (sk_ex == SK_BYTE) begin
          // merge byte into word read in exec cycle (mem_q)
          mwdata = addr[0] ? {sd_ex[7:0], mem_q[7:0]} : {mem_q[15:8], sd_ex[7:0]};
        end else begin
          mwdata = sd_ex;
        end
      end
      MA_LOAD: begin
        maddr = load_addr[AW-1:0];
        mwe   = cmd.load_item;
      end
      default: maddr = '0;
    endcase
  end

  // the exec cycle also reads the data word (for byte merge)
  logic [AW-1:0] raddr;
  logic          re;
  always_comb begin
    raddr = maddr;
    re    = cmd.mem_rd;
    if (cmd.exec) begin
      raddr = ex_addr[AW:1];
      re    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mwdata;
    if (re)  mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_init) clr_cnt <= '0;
    else if (cmd.clear_step) clr_cnt <= clr_cnt + 1'b1;
  end

  assign sts.clear_done = (clr_cnt == (AW+1)'(MEM_WORDS - 1));
  assign sts.pc_zero    = (pc == 16'h0000);

  always_comb begin
    op   = inst[15:12];
    dr   = inst[11:9];
    sr1  = inst[8:6];
    a    = rf[sr1];
    sx5  = {{11{inst[4]}}, inst[4:0]};
    sx6  = {{10{inst[5]}}, inst[5:0]};
    sx9  = {{7{inst[8]}}, inst[8:0]};
    sx11 = {{5{inst[10]}}, inst[10:0]};
    b    = inst[5] ? sx5 : rf[inst[2:0]];
    pc2  = pc + 16'd2;
    ex_pc = pc2;
    ex_v  = '0;
    ex_wr = 1'b0;
    ex_dr = dr;
    ex_setcc = 1'b0;
    ex_mem = 1'b0;
    ex_rd  = 1'b0;
    ex_sk  = SK_NONE;
    ex_addr = '0;
    case (op)
      OP_ADD: begin ex_v = a + b; ex_wr = 1'b1; ex_setcc = 1'b1; end
      OP_AND: begin ex_v = a & b; ex_wr = 1'b1; ex_setcc = 1'b1; end
      OP_XOR: begin ex_v = a ^ b; ex_wr = 1'b1; ex_setcc = 1'b1; end
      OP_BR: if ((dr & cc) != 3'b000) ex_pc = pc2 + {sx9[14:0], 1'b0};
      OP_JMP: ex_pc = a;
      OP_JSR: begin
        ex_pc = inst[11] ? pc2 + {sx11[14:0], 1'b0} : a;
        ex_dr = 3'd7; ex_v = pc2; ex_wr = 1'b1;
      end
      OP_LDB: begin
        ex_addr = a + sx6; ex_mem = 1'b1; ex_rd = 1'b1;
        ex_wr = 1'b1; ex_setcc = 1'b1;
      end
      OP_LDW: begin
        ex_addr = a + {sx6[14:0], 1'b0}; ex_mem = 1'b1; ex_rd = 1'b1;
        ex_wr = 1'b1; ex_setcc = 1'b1;
      end
      OP_LEA: begin ex_v = pc2 + {sx9[14:0], 1'b0}; ex_wr = 1'b1; end
      OP_SHF: begin
        ex_wr = 1'b1; ex_setcc = 1'b1;
        if (!inst[4])      ex_v = a << inst[3:0];
        else if (!inst[5]) ex_v = a >> inst[3:0];
        else               ex_v = 16'($signed(a) >>> inst[3:0]);
      end
      OP_STB: begin
        ex_addr = a + sx6; ex_mem = 1'b1; ex_sk = SK_BYTE;
      end
      OP_STW: begin
        ex_addr = (a + {sx6[14:0], 1'b0}) & 16'hFFFE; ex_mem = 1'b1; ex_sk = SK_WORD;
      end
      OP_TRAP: begin
        ex_addr = {7'd0, inst[7:0], 1'b0}; ex_mem = 1'b1; ex_rd = 1'b1;
        ex_dr = 3'd7; ex_v = pc2; ex_wr = 1'b1;
      end
      default: ;
    endcase
  end

  assign sts.needs_mem = ex_mem;

  logic [15:0] ld_v;
  logic [7:0]  ld_b;
  always_comb begin
    ld_b = addr[0] ? mem_q[15:8] : mem_q[7:0];
    ld_v = (op == OP_LDB) ? {{8{ld_b[7]}}, ld_b} : mem_q;
  end

  function automatic logic [2:0] cc_of(input logic [15:0] v);
    if (v[15]) return 3'b100;
    if (v == 16'h0000) return 3'b010;
    return 3'b001;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.inst_load) inst <= mem_q;
    if (cmd.exec) begin
      addr     <= ex_addr;
      mem_kind <= ex_rd;
      pc_ex    <= ex_pc;
      v_ex     <= ex_v;
      dr_ex    <= ex_dr;
      sk_ex    <= ex_sk;
      sd_ex    <= (ex_sk == SK_BYTE) ? {8'h00, rf[dr][7:0]} : rf[dr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      cc <= CC_Z;
      for (int i = 0; i < 8; i++) rf[i] <= '0;
      next_pc <= '0; halted <= 1'b0; cond_flags <= CC_Z;
      dest_written <= 1'b0; dest_index <= '0; dest_value <= '0;
      store_kind <= SK_NONE; store_addr <= '0; store_data <= '0;
    end else begin
      if (cfg_we) pc <= cfg_pc;
      if (cmd.load_item) begin
        next_pc <= pc; halted <= 1'b0; cond_flags <= cc;
        dest_written <= 1'b0; dest_index <= '0; dest_value <= '0;
        store_kind <= SK_WORD; store_addr <= {load_addr, 1'b0};
        store_data <= load_word;
      end
      if (cmd.halt_item) begin
        next_pc <= '0; halted <= 1'b1; cond_flags <= cc;
        dest_written <= 1'b0; dest_index <= '0; dest_value <= '0;
        store_kind <= SK_NONE; store_addr <= '0; store_data <= '0;
      end
      if (cmd.exec && !ex_mem) begin
        pc <= ex_pc;
        if (ex_wr) rf[ex_dr] <= ex_v;
        if (ex_setcc) cc <= cc_of(ex_v);
        next_pc <= ex_pc; halted <= 1'b0;
        cond_flags <= ex_setcc ? cc_of(ex_v) : cc;
        dest_written <= ex_wr;
        dest_index <= ex_wr ? ex_dr : 3'd0;
        dest_value <= ex_wr ? ex_v : 16'h0000;
        store_kind <= SK_NONE; store_addr <= '0; store_data <= '0;
      end
      if (cmd.finish) begin
        halted <= 1'b0;
        store_kind <= sk_ex;
        if (mem_kind) begin
          if (op == OP_TRAP) begin
            pc <= mem_q; next_pc <= mem_q;
            rf[dr_ex] <= v_ex;
            dest_value <= v_ex;
            cond_flags <= cc;
          end else begin
            pc <= pc_ex; next_pc <= pc_ex;
            rf[dr_ex] <= ld_v;
            dest_value <= ld_v;
            cc <= cc_of(ld_v);
            cond_flags <= cc_of(ld_v);
          end
          dest_written <= 1'b1; dest_index <= dr_ex;
          store_addr <= '0; store_data <= '0;
        end else begin
          pc <= pc_ex; next_pc <= pc_ex;
          cond_flags <= cc;
          dest_written <= 1'b0; dest_index <= '0; dest_value <= '0;
          store_addr <= addr; store_data <= sd_ex;
        end
      end
    end
  end

endmodule

// File: design/lc3b_instruction_executor.sv
// LC-3b executor top level: controller plus datapath, APB register port.
// Steps: load and halted items IDLE then DONE; ALU/branch items FETCH, EXEC;
// memory-access items (LDB, LDW, STB, STW, TRAP) also MEM, set by the single
// synchronous memory port (fetch read, then a data read or read-merge-write).
// One item at a time. Synchronous reset, then a clearing pass zeroes memory
// before the first item is taken.
module lc3b_instruction_executor #(
  parameter int MEM_WORDS = lc3b_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // item input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [14:0] load_addr,
  input  logic [15:0] load_word,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] next_pc,
  output logic        halted,
  output logic [2:0]  cond_flags,
  output logic        dest_written,
  output logic [2:0]  dest_index,
  output logic [15:0] dest_value,
  output logic [1:0]  store_kind,
  output logic [15:0] store_addr,
  output logic [15:0] store_data
);
  import lc3b_pkg::*;

  cmd_t        cmd;
  status_t     sts;
  logic [15:0] start_pc;
  logic        cfg_we;

  // only register 0 (start_pc) at byte address 0; paddr is its word bit
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && !paddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pc <= '0;
    end else if (cfg_we) begin
      start_pc <= pwdata[15:0];
    end
  end

  assign prdata = paddr ? 32'h0 : {16'h0, start_pc};

  lc3b_ctrl u_ctrl (
    .clk, .rst, .in_valid, .func, .in_ready, .out_valid, .out_ready,
    .sts, .cmd
  );

  lc3b_dp #(.MEM_WORDS(MEM_WORDS)) u_dp (
    .clk, .rst, .cmd, .sts,
    .cfg_we, .cfg_pc(pwdata[15:0]),
    .load_addr, .load_word,
    .next_pc, .halted, .cond_flags, .dest_written, .dest_index, .dest_value,
    .store_kind, .store_addr, .store_data
  );

endmodule
